/* hw/rtl/dct_pkg.sv */
package dct_pkg;

   // Default number of index entries built into the table.
   localparam int ENTRIES_DEFAULT = 16;

   // Reset values of the configuration registers.
   localparam logic [31:0] ARENA_CAPACITY_RESET = 32'd65536;
   localparam logic [4:0]  ENTRY_LIMIT_RESET    = 5'd16;

   // Configuration port geometry.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARENA_CAPACITY = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTRY_LIMIT    = 8'd1;

   // Request function codes.
   localparam logic FUNC_PUT = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        func;
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
      logic [31:0] object_length;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        found;
      logic [31:0] object_offset;
      logic [31:0] entry_length;
      logic [31:0] put_count;
      logic [31:0] dedup_count;
      logic [31:0] arena_fill;
   } rsp_type;

   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  value;
   } csr_type;

   // One row of the index: full digest with its arena placement.
   typedef struct packed {
      logic [255:0] key;
      logic [31:0]  offset;
      logic [31:0]  length;
   } entry_type;

endpackage

/* hw/rtl/dct_if.sv */
// Request channel.
interface dct_req_if import dct_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface dct_rsp_if import dct_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel.
interface dct_csr_if import dct_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dct_store.sv */
module dct_store import dct_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT,
   parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_row,
   input  logic          rd_en,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_row
);

   entry_type mem [ENTRIES];
   entry_type rd_row_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

/* hw/rtl/dedup_content_key_table_unit.sv */
// Deduplicating index keyed by a 256-bit content digest.
// The req_chan channel carries one transaction per request: func selects a
// put (insert or dedup) or a get, the digest comes as four 64-bit words and
// object_length gives the byte length for a put. Every request gives exactly
// one transaction on rsp_chan with status, found, offset, length and the
// updated put, dedup and arena fill counters.
// The csr_chan channel writes arena_capacity (index 0) and entry_limit
// (index 1); it is always ready. The user must write it only while the
// block is idle; the block itself does not enforce this. A request is
// accepted in the idle state, then the resident keys are scanned one per
// cycle through the registered read port of the entry memory, stopping at
// the first match, and a final state decides and updates the table. With
// an empty table the scan is skipped. The next request is accepted once
// the final state has been left and the block is back in idle.
// Synchronous reset empties the table, clears the counters and restores the
// register defaults; the entry memory itself is not cleared. If the receiver
// stalls, the result register holds and the final state waits for it.
module dedup_content_key_table_unit import dct_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dct_req_if.sink    req_chan,
   dct_rsp_if.source  rsp_chan,
   dct_csr_if.sink    csr_chan
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int LW = (CW > 5) ? CW : 5;

   state_type     state_ff, state_in;
   logic          func_ff, func_in;
   logic [255:0]  key_ff, key_in;
   logic [31:0]   len_ff, len_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          issuing_ff, issuing_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;
   logic          hit_ff, hit_in;
   logic [31:0]   hit_off_ff, hit_off_in;
   logic [31:0]   hit_len_ff, hit_len_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   used_ff, used_in;
   logic [31:0]   puts_ff, puts_in;
   logic [31:0]   dedups_ff, dedups_in;
   logic [31:0]   capacity_ff, capacity_in;
   logic [4:0]    limit_ff, limit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          req_take;
   logic          out_free;
   logic          match;
   logic          last_issue;
   logic [LW-1:0] limit_ext;
   logic [LW-1:0] limit_eff;
   logic          full;
   logic          wr_en;
   entry_type     wr_row;
   entry_type     rd_row;

   dct_store #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_row  (wr_row),
      .rd_en   (issuing_ff),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_row  (rd_row)
   );

   // Handshake terms.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Scan terms: the row read last cycle is compared with the request key.
   assign match      = pend_ff && (rd_row.key == key_ff);
   assign last_issue = ((scan_ff + CW'(1)) == count_ff);

   // Effective entry limit and the room check for a new key.
   assign limit_ext = LW'(limit_ff);
   assign limit_eff = (limit_ext < LW'(ENTRIES)) ? limit_ext : LW'(ENTRIES);
   assign full      = (LW'(count_ff) >= limit_eff) || (used_ff > capacity_ff)
                      || (len_ff > (capacity_ff - used_ff));

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match || (pend_ff && pend_last_ff)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of the sequencer.
   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      scan_in      = scan_ff;
      issuing_in   = 1'b0;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      hit_in       = hit_ff;
      hit_off_in   = hit_off_ff;
      hit_len_in   = hit_len_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      puts_in      = puts_ff;
      dedups_in    = dedups_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_row       = '{key: key_ff, offset: used_ff, length: len_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in    = req_chan.data.func;
               key_in     = {req_chan.data.key_word3, req_chan.data.key_word2,
                             req_chan.data.key_word1, req_chan.data.key_word0};
               len_in     = req_chan.data.object_length;
               scan_in    = '0;
               issuing_in = (count_ff != '0);
               hit_in     = 1'b0;
            end
         end
         ST_SCAN: begin
            // Issue the next read while comparing the previous row.
            if (issuing_ff) begin
               scan_in      = scan_ff + CW'(1);
               pend_in      = 1'b1;
               pend_last_in = last_issue;
               issuing_in   = !last_issue;
            end
            if (match) begin
               hit_in     = 1'b1;
               hit_off_in = rd_row.offset;
               hit_len_in = rd_row.length;
               issuing_in = 1'b0;
               pend_in    = 1'b0;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.status        = STATUS_OK;
               rsp_data_in.found         = 1'b0;
               rsp_data_in.object_offset = '0;
               rsp_data_in.entry_length  = '0;
               if (func_ff == FUNC_PUT) begin
                  puts_in = puts_ff + 32'd1;
                  if (hit_ff) begin
                     dedups_in                 = dedups_ff + 32'd1;
                     rsp_data_in.found         = 1'b1;
                     rsp_data_in.object_offset = hit_off_ff;
                     rsp_data_in.entry_length  = hit_len_ff;
                  end else if (full) begin
                     rsp_data_in.status = STATUS_FULL;
                  end else begin
                     // Append the key at the bump pointer.
                     wr_en                     = 1'b1;
                     rsp_data_in.object_offset = used_ff;
                     rsp_data_in.entry_length  = len_ff;
                     count_in                  = count_ff + CW'(1);
                     used_in                   = used_ff + len_ff;
                  end
               end else begin
                  if (hit_ff) begin
                     rsp_data_in.found         = 1'b1;
                     rsp_data_in.object_offset = hit_off_ff;
                     rsp_data_in.entry_length  = hit_len_ff;
                  end else begin
                     rsp_data_in.status = STATUS_MISS;
                  end
               end
               rsp_data_in.put_count   = puts_in;
               rsp_data_in.dedup_count = dedups_in;
               rsp_data_in.arena_fill  = used_in;
            end
         end
         default: begin
            issuing_in = 1'b0;
         end
      endcase
   end

   // Configuration register writes.
   always_comb begin
      capacity_in = capacity_ff;
      limit_in    = limit_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (csr_chan.data.index)
            CSR_ARENA_CAPACITY: capacity_in = csr_chan.data.value;
            CSR_ENTRY_LIMIT:    limit_in    = csr_chan.data.value[4:0];
            default:            ;
         endcase
      end
   end

   // Control state and counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issuing_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         used_ff      <= '0;
         puts_ff      <= '0;
         dedups_ff    <= '0;
         capacity_ff  <= ARENA_CAPACITY_RESET;
         limit_ff     <= ENTRY_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         puts_ff      <= puts_in;
         dedups_ff    <= dedups_in;
         capacity_ff  <= capacity_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      len_ff       <= len_in;
      scan_ff      <= scan_in;
      pend_last_ff <= pend_last_in;
      hit_ff       <= hit_in;
      hit_off_ff   <= hit_off_in;
      hit_len_ff   <= hit_len_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import dct_pkg::*;

   localparam int TABLE_DEPTH     = ENTRIES_DEFAULT;
   localparam int CANDIDATES      = 24;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 167;
   localparam int DIRECTED_ROWS   = 17;
   localparam int DRAIN_CYCLES    = 25;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int REPORT_LIMIT    = 10;

   // Digests used by the directed rows; apart from zero and all ones, each clears one 64-bit word of all ones.
   localparam logic [255:0] KEY_ZERO     = '0;
   localparam logic [255:0] KEY_ONES     = '1;
   localparam logic [255:0] KEY_W0_CLEAR = {64'h0, {192{1'b1}}};
   localparam logic [255:0] KEY_W1_CLEAR = {{64{1'b1}}, 64'h0, {128{1'b1}}};
   localparam logic [255:0] KEY_W2_CLEAR = {{128{1'b1}}, 64'h0, {64{1'b1}}};
   localparam logic [255:0] KEY_W3_CLEAR = {{192{1'b1}}, 64'h0};

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } directed_row_type;

   logic clock;
   logic reset;

   dct_req_if req_bus ();
   dct_rsp_if rsp_bus ();
   dct_csr_if csr_bus ();

   dedup_content_key_table_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the index and its registers.
   logic [255:0] resident_key [TABLE_DEPTH];
   logic [31:0]  resident_off [TABLE_DEPTH];
   logic [31:0]  resident_len [TABLE_DEPTH];
   int unsigned  resident_count;
   logic [31:0]  fill_bytes;
   logic [31:0]  puts_seen;
   logic [31:0]  dedups_seen;
   logic [31:0]  cap_bytes;
   logic [4:0]   limit_entries;

   rsp_type      replies_due [$];
   logic [255:0] candidate_keys [CANDIDATES];
   directed_row_type directed_rows [DIRECTED_ROWS];

   int mismatches;
   int replies_seen;
   int send_idle_pct;
   int recv_stall_pct;

   // Capacity and limit for each phase, with the idling mode that goes with it.
   logic [31:0] phase_capacity [PHASES] = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0400, 32'h0001_0000,
                                            32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
   logic [4:0]  phase_limit [PHASES]    = '{5'd16, 5'd0, 5'd8, 5'd12, 5'd31, 5'd0, 5'd17, 5'd0};
   int          phase_send [PHASES]     = '{0, 71, 0, 9, 0, 71, 0, 9};
   int          phase_recv [PHASES]     = '{0, 0, 71, 9, 0, 0, 71, 9};

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic req_type make_request(input logic op, input logic [255:0] digest,
                                            input logic [31:0] len);
      req_type r;
      r.func          = op;
      r.key_word0     = digest[255:192];
      r.key_word1     = digest[191:128];
      r.key_word2     = digest[127:64];
      r.key_word3     = digest[63:0];
      r.object_length = len;
      return r;
   endfunction

   function automatic rsp_type make_reply(input status_type st, input logic hit,
                                          input logic [31:0] off, input logic [31:0] len,
                                          input logic [31:0] puts, input logic [31:0] dedups,
                                          input logic [31:0] fill);
      rsp_type o;
      o.status        = st;
      o.found         = hit;
      o.object_offset = off;
      o.entry_length  = len;
      o.put_count     = puts;
      o.dedup_count   = dedups;
      o.arena_fill    = fill;
      return o;
   endfunction

   function automatic logic [255:0] fresh_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   // Search the shadow index, then insert, count a dedup or answer full or miss.
   function automatic rsp_type table_outcome(input req_type r);
      logic [255:0] digest;
      int           hit;
      int unsigned  usable;
      rsp_type      o;
      digest = {r.key_word0, r.key_word1, r.key_word2, r.key_word3};
      hit    = -1;
      for (int i = 0; i < resident_count; i++) begin
         if (hit < 0 && resident_key[i] == digest) hit = i;
      end
      usable   = (limit_entries < TABLE_DEPTH) ? limit_entries : TABLE_DEPTH;
      o        = '0;
      o.status = STATUS_OK;
      if (r.func == FUNC_PUT) begin
         puts_seen = puts_seen + 32'd1;
         if (hit >= 0) begin
            dedups_seen     = dedups_seen + 32'd1;
            o.found         = 1'b1;
            o.object_offset = resident_off[hit];
            o.entry_length  = resident_len[hit];
         end else if (resident_count >= usable || fill_bytes > cap_bytes
                      || r.object_length > cap_bytes - fill_bytes) begin
            o.status = STATUS_FULL;
         end else begin
            resident_key[resident_count] = digest;
            resident_off[resident_count] = fill_bytes;
            resident_len[resident_count] = r.object_length;
            o.object_offset = fill_bytes;
            o.entry_length  = r.object_length;
            resident_count  = resident_count + 1;
            fill_bytes      = fill_bytes + r.object_length;
         end
      end else begin
         if (hit >= 0) begin
            o.found         = 1'b1;
            o.object_offset = resident_off[hit];
            o.entry_length  = resident_len[hit];
         end else begin
            o.status = STATUS_MISS;
         end
      end
      o.put_count   = puts_seen;
      o.dedup_count = dedups_seen;
      o.arena_fill  = fill_bytes;
      return o;
   endfunction

   // Mostly resident keys and near misses of them, so that hits and dedups are common.
   function automatic req_type random_request();
      logic [255:0] digest;
      logic [31:0]  len;
      int unsigned  pick;
      pick = $urandom_range(99, 0);
      if (resident_count != 0 && pick < 40) begin
         digest = resident_key[$urandom_range(resident_count - 1, 0)];
      end else if (resident_count != 0 && pick < 55) begin
         digest = resident_key[$urandom_range(resident_count - 1, 0)]
                  ^ (256'd1 << $urandom_range(255, 0));
      end else if (pick < 85) begin
         digest = candidate_keys[$urandom_range(CANDIDATES - 1, 0)];
      end else begin
         digest = fresh_key();
      end
      pick = $urandom_range(99, 0);
      if (pick < 20) len = '0;
      else if (pick < 70) len = $urandom_range(255, 0);
      else len = $urandom;
      return make_request($urandom_range(1, 0) ? FUNC_GET : FUNC_PUT, digest, len);
   endfunction

   // Present one request transaction; the caller is at a falling edge and stays there.
   task automatic send_request(input req_type item, input bit typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= item;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = table_outcome(item);
      replies_due.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] reg_index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      csr_type w;
      w.index = reg_index;
      w.value = value;
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= w;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      if (reg_index == CSR_ARENA_CAPACITY) cap_bytes = value;
      else if (reg_index == CSR_ENTRY_LIMIT) limit_entries = value[4:0];
      @(negedge clock);
   endtask

   task automatic wait_for_replies();
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      replies_seen++;
      if (replies_due.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("reply %0d arrived with no request outstanding: status %0d offset %h",
                     replies_seen, got.status, got.object_offset);
      end else begin
         want = replies_due.pop_front();
         if (got.status !== want.status || got.found !== want.found
             || got.object_offset !== want.object_offset
             || got.entry_length !== want.entry_length
             || got.put_count !== want.put_count || got.dedup_count !== want.dedup_count
             || got.arena_fill !== want.arena_fill) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("reply %0d mismatch (expected / actual):", replies_seen);
               $display("  status %0d / %0d  found %0d / %0d", want.status, got.status,
                        want.found, got.found);
               $display("  offset %h / %h  length %h / %h", want.object_offset,
                        got.object_offset, want.entry_length, got.entry_length);
               $display("  puts %h / %h  dedups %h / %h  fill %h / %h", want.put_count,
                        got.put_count, want.dedup_count, got.dedup_count,
                        want.arena_fill, got.arena_fill);
            end
         end
      end
   endtask

   // Result receiver: ready changes on the falling edge, transactions are taken on the rising.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         check_reply(rsp_bus.data);
   end

   // Ends the run when no transaction of any kind has been accepted for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
             || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
             || (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.data   = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.data   = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      mismatches     = 0;
      replies_seen   = 0;
      resident_count = 0;
      fill_bytes     = '0;
      puts_seen      = '0;
      dedups_seen    = '0;
      cap_bytes      = ARENA_CAPACITY_RESET;
      limit_entries  = ENTRY_LIMIT_RESET;
      foreach (candidate_keys[i]) candidate_keys[i] = fresh_key();

      // Directed rows under the reset settings: empty table, dedup, arena exactly full.
      directed_rows[0]  = '{make_request(FUNC_GET, KEY_ZERO, 32'd0), 1'b1,
                            make_reply(STATUS_MISS, 1'b0, 0, 0, 0, 0, 0)};
      directed_rows[1]  = '{make_request(FUNC_PUT, KEY_ZERO, 32'd0), 1'b1,
                            make_reply(STATUS_OK, 1'b0, 0, 0, 1, 0, 0)};
      directed_rows[2]  = '{make_request(FUNC_PUT, KEY_ZERO, 32'd77), 1'b1,
                            make_reply(STATUS_OK, 1'b1, 0, 0, 2, 1, 0)};
      directed_rows[3]  = '{make_request(FUNC_PUT, KEY_ONES, 32'hFFFF_FFFF), 1'b1,
                            make_reply(STATUS_FULL, 1'b0, 0, 0, 3, 1, 0)};
      directed_rows[4]  = '{make_request(FUNC_PUT, KEY_ONES, 32'd65536), 1'b1,
                            make_reply(STATUS_OK, 1'b0, 0, 65536, 4, 1, 65536)};
      directed_rows[5]  = '{make_request(FUNC_GET, KEY_ONES, 32'hFFFF_FFFF), 1'b1,
                            make_reply(STATUS_OK, 1'b1, 0, 65536, 4, 1, 65536)};
      directed_rows[6]  = '{make_request(FUNC_PUT, KEY_W3_CLEAR, 32'd0), 1'b1,
                            make_reply(STATUS_OK, 1'b0, 65536, 0, 5, 1, 65536)};
      directed_rows[7]  = '{make_request(FUNC_PUT, KEY_W0_CLEAR, 32'd1), 1'b1,
                            make_reply(STATUS_FULL, 1'b0, 0, 0, 6, 1, 65536)};
      directed_rows[8]  = '{make_request(FUNC_GET, KEY_W0_CLEAR, 32'd0), 1'b1,
                            make_reply(STATUS_MISS, 1'b0, 0, 0, 6, 1, 65536)};
      directed_rows[9]  = '{make_request(FUNC_GET, KEY_W3_CLEAR, 32'd0), 1'b1,
                            make_reply(STATUS_OK, 1'b1, 65536, 0, 6, 1, 65536)};
      directed_rows[10] = '{make_request(FUNC_PUT, KEY_W1_CLEAR, 32'd0), 1'b0, '0};
      directed_rows[11] = '{make_request(FUNC_GET, KEY_W2_CLEAR, 32'd0), 1'b0, '0};
      directed_rows[12] = '{make_request(FUNC_PUT, KEY_ONES, 32'd0), 1'b0, '0};
      directed_rows[13] = '{make_request(FUNC_GET, 256'd1, 32'd0), 1'b0, '0};
      directed_rows[14] = '{make_request(FUNC_PUT, KEY_W2_CLEAR, 32'd0), 1'b0, '0};
      directed_rows[15] = '{make_request(FUNC_GET, KEY_ZERO, 32'hAAAA_5555), 1'b0, '0};
      directed_rows[16] = '{make_request(FUNC_PUT, 256'd1 << 255, 32'h8000_0000), 1'b0, '0};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      req_bus.valid <= 1'b0;
      wait_for_replies();

      // Random phases, each with its own register settings and idling mode.
      for (int p = 0; p < PHASES; p++) begin
         if (p == 5) begin
            phase_capacity[p] = $urandom;
            phase_limit[p]    = 5'($urandom_range(31, 0));
         end
         write_register(CSR_ARENA_CAPACITY, phase_capacity[p]);
         write_register(CSR_ENTRY_LIMIT, {27'd0, phase_limit[p]});
         csr_bus.valid  <= 1'b0;
         send_idle_pct   = phase_send[p];
         recv_stall_pct <= phase_recv[p];
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request(), 1'b0, '0);
         req_bus.valid <= 1'b0;
         wait_for_replies();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/dct_pkg.sv
hw/rtl/dct_if.sv
hw/rtl/dct_store.sv
hw/rtl/dedup_content_key_table_unit.sv
tb/tb_top.sv
